// ===== hw/rtl/htskm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htskm_pkg
// shared types and constants of the string key map
// ----------------------------------------------------------------------------
package htskm_pkg;

    localparam logic [31:0] HASH_START = 32'd16777619;
    localparam logic [31:0] HASH_MULT  = 32'd2166136261;
    localparam int unsigned MIN_LOG2   = 4;

    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    localparam logic [2:0] ST_FOUND     = 3'd0;
    localparam logic [2:0] ST_INSERTED  = 3'd1;
    localparam logic [2:0] ST_REMOVED   = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    // hash unit result toward the probe engine
    typedef struct packed {
        logic        valid;
        logic [31:0] hash;
    } t_hash_res;

endpackage

// ===== hw/rtl/htskm_hash.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htskm_hash
// byte-serial key hash, one xor and multiply per cycle
// ----------------------------------------------------------------------------
module htskm_hash #(
    parameter int KEY_BYTES = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [3:0]                i_len,
    input  logic [8*KEY_BYTES-1:0]    i_key,
    output htskm_pkg::t_hash_res      o_res
);
    localparam int CW = $clog2(KEY_BYTES + 1);

    logic              r_busy;
    logic [CW-1:0]     r_idx;
    logic [CW-1:0]     r_len;
    logic [8*KEY_BYTES-1:0] r_key;
    logic [31:0]       r_hash;
    logic              r_done;
    logic [31:0]       w_byte;
    logic [31:0]       w_prod;

    assign w_byte = {{24{r_key[7]}}, r_key[7:0]};
    // only the low 32 bits of the product are kept
    assign w_prod = (r_hash ^ w_byte) * htskm_pkg::HASH_MULT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
                r_len  <= CW'(i_len);
                r_key  <= i_key;
                r_hash <= htskm_pkg::HASH_START;
            end else if (r_busy) begin
                if (r_idx == r_len) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_hash <= w_prod;
                    r_key  <= r_key >> 8;
                    r_idx  <= r_idx + 1'b1;
                end
            end
        end
    end

    assign o_res.valid = r_done;
    assign o_res.hash  = r_hash;
endmodule

// ===== hw/rtl/htskm_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htskm_table
// slot memory: used marks plus stored hash, length and key
// ----------------------------------------------------------------------------
module htskm_table #(
    parameter int SLOTS     = 1024,
    parameter int KEY_BYTES = 8
) (
    input  logic                         i_clk,
    input  logic [$clog2(SLOTS)-1:0]     i_raddr,
    output logic                         o_used,
    output logic [31:0]                  o_hash,
    output logic [3:0]                   o_len,
    output logic [8*KEY_BYTES-1:0]       o_key,
    input  logic                         i_we,
    input  logic [$clog2(SLOTS)-1:0]     i_waddr,
    input  logic [31:0]                  i_hash,
    input  logic [3:0]                   i_len,
    input  logic [8*KEY_BYTES-1:0]       i_key,
    input  logic                         i_used_we,
    input  logic                         i_used,
    input  logic                         i_used_rd_valid
);
    localparam int DW = 36 + 8*KEY_BYTES;
    logic [DW-1:0] r_mem [SLOTS];
    logic          r_used_mem [SLOTS];
    logic [DW-1:0] r_rd;
    logic          r_used_rd;

    always_ff @(posedge i_clk) begin
        if (i_we)
            r_mem[i_waddr] <= {i_hash, i_len, i_key};
        r_rd <= r_mem[i_raddr];
    end

    // used marks: written by the clear sweep or by the engine
    always_ff @(posedge i_clk) begin
        if (i_used_we)
            r_used_mem[i_waddr] <= i_used;
        r_used_rd <= r_used_mem[i_raddr];
    end

    assign o_used = r_used_rd & i_used_rd_valid;
    assign {o_hash, o_len, o_key} = r_rd;
endmodule

// ===== hw/rtl/hash_table_string_key_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_table_string_key_map
// open-addressed key map with quadratic probing over a slot memory
// ----------------------------------------------------------------------------
// usage:
//   requests enter on i_valid/o_stall with command, key length and key bytes.
//   each request yields one result on o_valid/i_stall: status, slot, count.
//   the key is hashed one byte per cycle, then the slot memory is probed with
//   one read per probe (an address state, then a compare state on the
//   registered read data), up to PROBES probes, and a done state loads the
//   output register. a write back of the claimed or removed slot happens in
//   the compare cycle and ends the request, so no probe sees it. the next
//   request is taken once the engine is back in idle; one is in work at a time.
//   the result sits in an output register; a new request is taken while it
//   waits, and the engine holds its finished result until the register frees.
//   after reset a clearing pass writes every used mark to zero, one slot per
//   cycle; no request is taken meanwhile. configuration writes are taken at
//   any time, intended only while idle.
// ----------------------------------------------------------------------------
module hash_table_string_key_map #(
    parameter int SLOTS     = 1024,
    parameter int PROBES    = 8,
    parameter int KEY_BYTES = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_command,
    input  logic [3:0]                  i_key_len,
    input  logic [63:0]                 i_key_bytes,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [2:0]                  o_status,
    output logic [9:0]                  o_slot_index,
    output logic [10:0]                 o_entry_count,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [3:0]                  i_cfg_data
);
    localparam int AW = $clog2(SLOTS);
    localparam int PW = $clog2(PROBES + 1);
    localparam int KW = 8 * KEY_BYTES;
    localparam int CNTW = AW + 1;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_ADDR  = 3'd3;
    localparam logic [2:0] S_CMP   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]      r_state;
    logic [AW-1:0]   r_clr;
    logic [3:0]      r_cap;
    logic [1:0]      r_cmd;
    logic [3:0]      r_len;
    logic [KW-1:0]   r_key;
    logic [31:0]     r_hash;
    logic [PW-1:0]   r_probe;
    logic [AW-1:0]   r_slot;
    logic [CNTW-1:0] r_count;
    logic [2:0]      r_res_status;
    logic [AW-1:0]   r_res_slot;
    logic            r_ovalid;
    logic [2:0]      r_ostatus;
    logic [9:0]      r_oslot;
    logic [10:0]     r_ocount;

    logic [3:0]      w_len;
    logic [KW-1:0]   w_key;
    logic            w_accept;
    logic [AW-1:0]   w_mask;
    logic [3:0]      w_lg;
    logic [31:0]     w_paddr;
    logic [AW-1:0]   w_raddr;
    logic            w_oload;
    htskm_pkg::t_hash_res w_hres;
    logic            w_used;
    logic [31:0]     w_thash;
    logic [3:0]      w_tlen;
    logic [KW-1:0]   w_tkey;
    logic            w_match;
    logic            w_we;
    logic            w_used_we;
    logic            w_used_val;
    logic [AW-1:0]   w_waddr;
    logic            w_last;

    // saturate length and zero bytes past it
    always_comb begin
        w_len = (i_key_len > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : i_key_len;
        for (int b = 0; b < KEY_BYTES; b++)
            w_key[8*b +: 8] = (4'(b) < w_len) ? i_key_bytes[8*b +: 8] : 8'd0;
    end

    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    // capacity mask, log2 at least 4 (16 slots), saturated at SLOTS
    always_comb begin
        w_lg = (r_cap < 4'(htskm_pkg::MIN_LOG2)) ? 4'(htskm_pkg::MIN_LOG2) : r_cap;
        w_mask = AW'((32'd1 << w_lg) - 32'd1);
    end

    assign w_paddr = r_hash + 32'(r_probe) * 32'(r_probe);

    // probe address goes to the memory in the address cycle so that the
    // registered read data belongs to it in the compare cycle
    assign w_raddr = (r_state == S_ADDR) ? (w_paddr[AW-1:0] & w_mask) : r_slot;

    // output register loads when free or being drained
    assign w_oload = (r_state == S_DONE) && (!r_ovalid || !i_stall);

    htskm_hash #(.KEY_BYTES(KEY_BYTES)) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_len   (w_len),
        .i_key   (w_key),
        .o_res   (w_hres)
    );

    assign w_match = w_used && (w_thash == r_hash) && (w_tlen == r_len) && (w_tkey == r_key);
    assign w_last  = (r_probe == PW'(PROBES - 1));

    always_comb begin
        w_we = 1'b0;
        w_used_we = 1'b0;
        w_used_val = 1'b0;
        w_waddr = r_slot;
        if (r_state == S_CLEAR) begin
            w_used_we = 1'b1;
            w_waddr = r_clr;
        end else if (r_state == S_CMP) begin
            if (w_match && r_cmd == htskm_pkg::CMD_REMOVE) begin
                w_used_we = 1'b1;
            end else if (!w_used && r_cmd == htskm_pkg::CMD_INSERT) begin
                w_we = 1'b1;
                w_used_we = 1'b1;
                w_used_val = 1'b1;
            end
        end
    end

    htskm_table #(.SLOTS(SLOTS), .KEY_BYTES(KEY_BYTES)) u_table (
        .i_clk           (i_clk),
        .i_raddr         (w_raddr),
        .o_used          (w_used),
        .o_hash          (w_thash),
        .o_len           (w_tlen),
        .o_key           (w_tkey),
        .i_we            (w_we),
        .i_waddr         (w_waddr),
        .i_hash          (r_hash),
        .i_len           (r_len),
        .i_key           (r_key),
        .i_used_we       (w_used_we),
        .i_used          (w_used_val),
        .i_used_rd_valid (1'b1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_cap    <= 4'(htskm_pkg::MIN_LOG2);
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid)
                r_cap <= i_cfg_data;
            if (w_oload)
                r_ovalid <= 1'b1;
            else if (!i_stall)
                r_ovalid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(SLOTS - 1))
                        r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd   <= i_command;
                        r_len   <= w_len;
                        r_key   <= w_key;
                        r_state <= S_HASH;
                    end
                end
                S_HASH: begin
                    if (w_hres.valid) begin
                        r_hash  <= w_hres.hash;
                        r_probe <= '0;
                        r_res_status <= (r_cmd == htskm_pkg::CMD_INSERT) ?
                                        htskm_pkg::ST_FULL : htskm_pkg::ST_NOT_FOUND;
                        r_res_slot <= '0;
                        r_state <= S_ADDR;
                    end
                end
                S_ADDR: begin
                    r_slot  <= w_raddr;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (w_match) begin
                        r_res_slot <= r_slot;
                        if (r_cmd == htskm_pkg::CMD_REMOVE) begin
                            r_res_status <= htskm_pkg::ST_REMOVED;
                            r_count <= r_count - 1'b1;
                        end else begin
                            r_res_status <= htskm_pkg::ST_FOUND;
                        end
                        r_state <= S_DONE;
                    end else if (!w_used && r_cmd == htskm_pkg::CMD_INSERT) begin
                        r_res_slot   <= r_slot;
                        r_res_status <= htskm_pkg::ST_INSERTED;
                        r_count <= r_count + 1'b1;
                        r_state <= S_DONE;
                    end else if (w_last) begin
                        r_state <= S_DONE;
                    end else begin
                        r_probe <= r_probe + 1'b1;
                        r_state <= S_ADDR;
                    end
                end
                S_DONE: begin
                    if (w_oload) begin
                        r_ostatus <= r_res_status;
                        r_oslot   <= 10'(r_res_slot);
                        r_ocount  <= 11'(r_count);
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid       = r_ovalid;
    assign o_status      = r_ostatus;
    assign o_slot_index  = r_oslot;
    assign o_entry_count = r_ocount;

    // a stalled result holds its valid, status and entry count
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_entry_count))
        else $error("result changed while stalled");
    // no request is taken during the clearing pass
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> o_stall)
        else $error("request taken while clearing");
    // count never exceeds the slot total
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(SLOTS))
        else $error("entry count overflow");
endmodule
